// File: hdl/wapmm_pkg.sv
// Shared widths, result kinds and defaults for the windowed average pace block.
// Used by the top level and by the serial divider; depends on nothing.
package wapmm_pkg;

  localparam int unsigned MIN_W          = 10;   // minutes field
  localparam int unsigned SEC_W          = 6;    // seconds field
  localparam int unsigned PACE_W         = 16;   // pace in seconds
  localparam int unsigned SUM_W          = 22;   // running window sum
  localparam int unsigned LEN_W          = 7;    // window length register
  localparam int unsigned KIND_W         = 2;    // result kind
  localparam int unsigned SEC_PER_MIN    = 60;
  localparam int unsigned WINDOW_MAX_DEF = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_AVG  = 2'd0,
    KIND_FAST = 2'd1,
    KIND_SLOW = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

endpackage

// File: hdl/wapmm_div.sv
// Restoring radix-2 divider: one quotient bit per cycle, unsigned operands.
// Used by the windowed average pace top level; widths default from wapmm_pkg.
module wapmm_div #(
  parameter int unsigned DIVIDEND_W = wapmm_pkg::SUM_W,
  parameter int unsigned DIVISOR_W  = wapmm_pkg::LEN_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] work_q, work_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  divisor_q, divisor_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  ge;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  assign rem_sh   = {rem_q, work_q[DIVIDEND_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor_q};
  assign ge       = rem_sh >= {1'b0, divisor_q};

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    work_d    = work_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = CNT_W'(DIVIDEND_W);
      work_d    = dividend_i;
      rem_d     = '0;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      work_d = {work_q[DIVIDEND_W-2:0], ge};
      rem_d  = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign done_o     = done_q;
  assign quotient_o = work_q;

endmodule

// File: hdl/windowed_average_pace_min_max.sv
// Windowed average pace with fastest and slowest average: top level.
// Depends on wapmm_pkg and instantiates the serial divider wapmm_div.
//
// Each input beat carries one pace as minutes and seconds. The block keeps
// the last window paces in a single-port-write, registered-read memory and a
// running sum; once a window is full every beat yields the truncated window
// average, and on a beat with tlast the fastest and slowest averages follow,
// the last of them with tlast, before the run starts over. A run that ends
// before its first full window gives one error beat instead. The block works
// on one beat at a time: it takes no new beat until the last one is through
// and all of its result beats are taken. A beat that yields a result waits
// for the bit-per-cycle divider over the running sum before its first result
// beat appears. Writing the window length also restarts the run. No clearing
// pass is needed after reset.
module windowed_average_pace_min_max #(
  parameter int unsigned WINDOW_MAX = wapmm_pkg::WINDOW_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Window length register.
  input  logic                          cfg_we_i,
  input  logic [wapmm_pkg::LEN_W-1:0]   cfg_wdata_i,
  // Input beats.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [9:0] minutes, [15:10] seconds
  input  logic                          s_axis_tlast,  // last_record
  // Result beats.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [15:0] pace_seconds
  output logic [1:0]                    m_axis_tuser,  // [1:0] result_kind
  output logic                          m_axis_tlast   // end_of_run
);

  localparam int unsigned LEN_W   = wapmm_pkg::LEN_W;
  localparam int unsigned SUM_W   = wapmm_pkg::SUM_W;
  localparam int unsigned PACE_W  = wapmm_pkg::PACE_W;
  localparam int unsigned MIN_W   = wapmm_pkg::MIN_W;
  localparam int unsigned SEC_W   = wapmm_pkg::SEC_W;
  localparam int unsigned SLOT_W  = $clog2(WINDOW_MAX);
  localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
  localparam int unsigned LEN_CAP = (WINDOW_MAX < LEN_MAX) ? WINDOW_MAX : LEN_MAX;
  localparam int unsigned CALC_W  = ((SLOT_W > LEN_W) ? SLOT_W : LEN_W) + 2;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_UPD  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_AVG  = 7'b0001000,
    ST_FAST = 7'b0010000,
    ST_SLOW = 7'b0100000,
    ST_ERR  = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [LEN_W-1:0]     fill_q, fill_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [PACE_W-1:0]    fast_q, fast_d;
  logic [PACE_W-1:0]    slow_q, slow_d;
  logic                 out_valid_q, out_valid_d;
  logic [PACE_W-1:0]    out_pace_q, out_pace_d;
  wapmm_pkg::kind_e     out_kind_q, out_kind_d;
  logic                 out_last_q, out_last_d;
  logic [PACE_W-1:0]    pace_q, pace_d;
  logic                 last_q, last_d;

  logic [PACE_W-1:0]    store [WINDOW_MAX];
  logic [PACE_W-1:0]    rd_data_q;
  logic                 mem_we;

  logic [LEN_W-1:0]     eff_len;
  logic                 full;
  logic [LEN_W-1:0]     fill_after;
  logic [CALC_W-1:0]    old_calc;
  logic [SLOT_W-1:0]    old_addr;
  logic                 s_accept;
  logic                 m_accept;
  logic [MIN_W-1:0]     in_min;
  logic [SEC_W-1:0]     in_sec;
  logic [PACE_W-1:0]    in_pace;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     div_quot;
  logic [PACE_W-1:0]    avg;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_accept = m_axis_tvalid && m_axis_tready;

  assign in_min  = s_axis_tdata[MIN_W-1:0];
  assign in_sec  = s_axis_tdata[MIN_W+SEC_W-1:MIN_W];
  assign in_pace = PACE_W'(in_min * PACE_W'(wapmm_pkg::SEC_PER_MIN)) + PACE_W'(in_sec);

  // A length of zero means one; lengths above the store depth are capped.
  always_comb begin
    if (len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(len_q) > LEN_CAP) begin
      eff_len = LEN_W'(LEN_CAP);
    end else begin
      eff_len = len_q;
    end
  end

  assign full       = fill_q >= eff_len;
  assign fill_after = full ? fill_q : fill_q + LEN_W'(1);

  // Slot that leaves the window, wrapping around the ring.
  always_comb begin
    if (CALC_W'(slot_q) >= CALC_W'(eff_len)) begin
      old_calc = CALC_W'(slot_q) - CALC_W'(eff_len);
    end else begin
      old_calc = CALC_W'(slot_q) + CALC_W'(WINDOW_MAX) - CALC_W'(eff_len);
    end
  end
  assign old_addr = old_calc[SLOT_W-1:0];

  assign avg = div_quot[PACE_W-1:0];

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    sum_d       = sum_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    fast_d      = fast_q;
    slow_d      = slow_q;
    out_valid_d = out_valid_q;
    out_pace_d  = out_pace_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    pace_d      = pace_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          pace_d  = in_pace;
          last_d  = s_axis_tlast;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        // The leaving entry was read in the accept cycle and is in rd_data_q now.
        mem_we = 1'b1;
        sum_d  = sum_q - (full ? SUM_W'(rd_data_q) : '0) + SUM_W'(pace_q);
        fill_d = fill_after;
        slot_d = (32'(slot_q) == WINDOW_MAX - 1) ? '0 : slot_q + SLOT_W'(1);
        if (fill_after >= eff_len) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else if (last_q) begin
          out_valid_d = 1'b1;
          out_kind_d  = wapmm_pkg::KIND_ERR;
          out_pace_d  = '0;
          out_last_d  = 1'b1;
          sum_d       = '0;
          fill_d      = '0;
          slot_d      = '0;
          fast_d      = '1;
          slow_d      = '0;
          state_d     = ST_ERR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (avg < fast_q) fast_d = avg;
          if (avg > slow_q) slow_d = avg;
          out_valid_d = 1'b1;
          out_kind_d  = wapmm_pkg::KIND_AVG;
          out_pace_d  = avg;
          out_last_d  = 1'b0;
          state_d     = ST_AVG;
        end
      end
      ST_AVG: begin
        if (m_accept) begin
          if (last_q) begin
            out_kind_d = wapmm_pkg::KIND_FAST;
            out_pace_d = fast_q;
            out_last_d = 1'b0;
            state_d    = ST_FAST;
          end else begin
            out_valid_d = 1'b0;
            state_d     = ST_IDLE;
          end
        end
      end
      ST_FAST: begin
        if (m_accept) begin
          out_kind_d = wapmm_pkg::KIND_SLOW;
          out_pace_d = slow_q;
          out_last_d = 1'b1;
          state_d    = ST_SLOW;
        end
      end
      ST_SLOW: begin
        if (m_accept) begin
          out_valid_d = 1'b0;
          sum_d       = '0;
          fill_d      = '0;
          slot_d      = '0;
          fast_d      = '1;
          slow_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (m_accept) begin
          out_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b0;
      end
    endcase

    // A new window length restarts the run.
    if (cfg_we_i) begin
      len_d  = cfg_wdata_i;
      sum_d  = '0;
      fill_d = '0;
      slot_d = '0;
      fast_d = '1;
      slow_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(1);
      sum_q       <= '0;
      fill_q      <= '0;
      slot_q      <= '0;
      fast_q      <= '1;
      slow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      fast_q      <= fast_d;
      slow_q      <= slow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pace_q <= out_pace_d;
    out_kind_q <= out_kind_d;
    out_last_q <= out_last_d;
    pace_q     <= pace_d;
    last_q     <= last_d;
  end

  // Window store: written in the update cycle, read in the accept cycle that comes before it.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[slot_q] <= pace_q;
    end
    if (s_accept) begin
      rd_data_q <= store[old_addr];
    end
  end

  wapmm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (eff_len),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pace_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_input_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result beat is pending");

  a_accept_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_UPD))
    else $error("accepted beat not followed by the update cycle");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_len)
    else $error("fill count exceeds the window length");

  a_slowest_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == wapmm_pkg::KIND_SLOW ||
                       m_axis_tuser == wapmm_pkg::KIND_ERR)) |-> m_axis_tlast)
    else $error("final result beat without end of run");

  a_avg_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser != wapmm_pkg::KIND_AVG))
    else $error("window average marked as end of run");
`endif

endmodule
